/* hdl/skl_pkg.sv */
// Package for the sorted key list: field widths, operation and status codes,
// controller states and the payload structs of both channels.
// Depends on nothing; sorted_key_list imports it.
package skl_pkg;

    localparam int SKL_CAPACITY = 64;
    localparam int KEY_W        = 32;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 3;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DUMPED   = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_DUMP,
        S_RES
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
    } t_skl_in;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] value;
        logic                    last;
    } t_skl_out;

endpackage

/* hdl/skl_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module skl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/sorted_key_list.sv */
// Top level of the sorted key list: controller, output register and key RAM.
// Depends on skl_pkg and skl_ram.
//
// Keeps up to CAPACITY signed keys in ascending order in one RAM.
// Input channel: i_in_valid / o_in_stall with i_in_data (kind, key).
// Output channel: o_out_valid / i_out_stall with o_out_data (status, value, last).
// One item is worked on at a time; o_in_stall is high while an item is in work.
// An insert scans from the top of the list downward, moving each larger or
// equal key up one slot, one RAM read and one write per cycle. The scan ends
// with the write of the new key; its result then waits in the result state
// until the output register is free, and the next item is accepted after
// it is loaded. A delete always scans all n stored keys and closes the gap
// behind the found key, then gives its result the same way. Full and empty
// cases go straight to the result state; an unused kind gives no result.
// A dump first primes the RAM read, then gives one key per cycle while the
// receiver does not stall; the next item is accepted once the last key is loaded.
// This pacing comes from the single RAM read port and its registered read.
// Every insert and delete gives one result with last set; a dump of n keys gives
// n results, the final one with last set, or one empty status for an empty list.
// Results go through an output register, so the next item is accepted while
// the last result waits. While the receiver stalls, a dump pauses and the RAM
// re-reads the same entry. Reset empties the list at once; no clearing pass.
module sorted_key_list #(
    parameter int CAPACITY = skl_pkg::SKL_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  skl_pkg::t_skl_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output skl_pkg::t_skl_out  o_out_data
);
    import skl_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CapC = CW'(CAPACITY);
    localparam logic [CW-1:0] OneC = CW'(1);
    localparam logic [CW-1:0] TwoC = CW'(2);

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_ptr, n_ptr;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_prim, n_prim;
    logic                    r_found, n_found;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [STATUS_W-1:0]     r_res_status, n_res_status;
    logic signed [KEY_W-1:0] r_res_value, n_res_value;
    t_skl_out                r_out, n_out;
    logic                    r_out_valid;
    logic                    out_load;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [KEY_W-1:0] ram_wdata;
    logic [CW-1:0]    ram_rsel;
    logic [KEY_W-1:0] ram_rdata;

    logic accept, out_free, rd_ge, rd_eq;
    logic ins_adv, ins_done, del_step, del_last, dump_take, dump_last;

    skl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_rsel[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign rd_ge = $signed(ram_rdata) >= r_key;
    assign rd_eq = (ram_rdata == r_key);

    // In INS, r_ptr is the slot being decided and the RAM data is the entry below it.
    assign ins_adv  = (r_state == S_INS) && r_prim && (r_ptr != '0) && rd_ge;
    assign ins_done = (r_state == S_INS) && ((r_ptr == '0) || (r_prim && !rd_ge));
    // In DEL and DUMP, r_ptr is the index of the entry on the RAM data.
    assign del_step  = (r_state == S_DEL) && r_prim;
    assign del_last  = del_step && (r_ptr == (r_count - OneC));
    assign dump_take = (r_state == S_DUMP) && r_prim && out_free;
    assign dump_last = dump_take && (r_ptr == (r_count - OneC));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.kind)
                        KIND_INSERT: n_state = (r_count == CapC) ? S_RES : S_INS;
                        KIND_DELETE: n_state = (r_count == '0) ? S_RES : S_DEL;
                        KIND_DUMP:   n_state = (r_count == '0) ? S_RES : S_DUMP;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_INS: begin
                if (ins_done) n_state = S_RES;
            end
            S_DEL: begin
                if (del_last) n_state = S_RES;
            end
            S_DUMP: begin
                if (dump_last) n_state = S_IDLE;
            end
            S_RES: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ptr        = r_ptr;
        n_count      = r_count;
        n_prim       = r_prim;
        n_found      = r_found;
        n_key        = r_key;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_out        = r_out;
        out_load     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_ptr[AW-1:0];
        ram_wdata    = r_key;
        ram_rsel     = r_ptr;
        case (r_state)
            S_IDLE: begin
                n_prim      = 1'b0;
                n_found     = 1'b0;
                n_key       = i_in_data.key;
                n_res_value = i_in_data.key;
                if (i_in_data.kind == KIND_INSERT) begin
                    n_ptr        = r_count;
                    ram_rsel     = r_count - OneC;
                    n_res_status = ST_FULL;
                end else begin
                    n_ptr        = '0;
                    ram_rsel     = '0;
                    n_res_status = ST_EMPTY;
                    if (i_in_data.kind == KIND_DUMP) n_res_value = '0;
                end
            end
            S_INS: begin
                n_prim   = 1'b1;
                ram_rsel = ins_adv ? (r_ptr - TwoC) : (r_ptr - OneC);
                if (ins_adv) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    n_ptr     = r_ptr - OneC;
                end
                if (ins_done) begin
                    ram_we       = 1'b1;
                    n_count      = r_count + OneC;
                    n_res_status = ST_INSERTED;
                end
            end
            S_DEL: begin
                n_prim   = 1'b1;
                ram_rsel = r_prim ? (r_ptr + OneC) : r_ptr;
                if (del_step) begin
                    n_ptr = r_ptr + OneC;
                    if (r_found) begin
                        // Every key after the match moves down one slot.
                        ram_we    = 1'b1;
                        ram_waddr = AW'(r_ptr - OneC);
                        ram_wdata = ram_rdata;
                    end else if (rd_eq) begin
                        n_found = 1'b1;
                    end
                end
                if (del_last) begin
                    if (r_found || rd_eq) begin
                        n_res_status = ST_DELETED;
                        n_count      = r_count - OneC;
                    end else begin
                        n_res_status = ST_NOTFOUND;
                    end
                end
            end
            S_DUMP: begin
                n_prim   = 1'b1;
                ram_rsel = dump_take ? (r_ptr + OneC) : r_ptr;
                if (dump_take) begin
                    n_ptr        = r_ptr + OneC;
                    out_load     = 1'b1;
                    n_out.status = ST_DUMPED;
                    n_out.value  = $signed(ram_rdata);
                    n_out.last   = dump_last;
                end
            end
            S_RES: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    n_out.status = r_res_status;
                    n_out.value  = r_res_value;
                    n_out.last   = 1'b1;
                end
            end
            default: begin
                n_prim = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_prim      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_prim  <= n_prim;
            r_found <= n_found;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_key        <= n_key;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CapC)
        else $error("key count exceeds capacity");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_INS || r_state == S_DEL))
        else $error("key RAM written outside insert or delete");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) || r_count == $past(r_count) + OneC
                  || r_count == $past(r_count) - OneC))
        else $error("key count changed by more than one");

    a_del_waddr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state == S_DEL) |-> (CW'(ram_waddr) < r_count))
        else $error("delete wrote beyond the stored keys");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("output register loaded while a result is stalled");

endmodule
